[hdl/sem_pkg.sv]
// ---------------------------------------------------------------------------
// sem_pkg
// shared constants, types and register codes of the sobel edge magnitude unit
// ---------------------------------------------------------------------------
package sem_pkg;

   // line store depth, one entry per pixel column
   localparam int MAX_WIDTH = 1024;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);

   localparam int LW_BITS   = 11;
   localparam int FH_BITS   = 16;
   localparam int IROW_BITS = 17;
   localparam int OROW_BITS = 16;

   localparam int CH_BITS   = 8;
   localparam int PIX_BITS  = 3 * CH_BITS;
   localparam int SUM3_BITS = CH_BITS + 2;
   localparam int GRAD_BITS = SUM3_BITS + 1;
   localparam int SQ_BITS   = 2 * SUM3_BITS;
   localparam int RAD_BITS  = 2 * CH_BITS;

   localparam int LW_RESET  = 640;
   localparam int FH_RESET  = 480;

   // magnitudes above this sum of squares round to the cap
   localparam int MAG_CAP_SUM = 65280;
   localparam int MAG_MAX     = 255;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // register index, taken from the word address
   localparam logic REG_LINE_WIDTH   = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef logic [PIX_BITS-1:0]         pixel_type;
   typedef logic signed [GRAD_BITS-1:0] grad_type;

   typedef struct packed {
      logic               done;
      logic [CH_BITS-1:0] mag;
   } mag_result_type;

endpackage

[hdl/sem_ram.sv]
// ---------------------------------------------------------------------------
// sem_ram
// generic single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sem_magnitude.sv]
// ---------------------------------------------------------------------------
// sem_magnitude
// rounded edge magnitude of one color lane, bit-serial square root
// ---------------------------------------------------------------------------
module sem_magnitude (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  sem_pkg::grad_type       gx,
   input  sem_pkg::grad_type       gy,
   output sem_pkg::mag_result_type result
);

   localparam logic [1:0] MG_IDLE  = 2'd0;
   localparam logic [1:0] MG_SUM   = 2'd1;
   localparam logic [1:0] MG_ITER  = 2'd2;
   localparam logic [1:0] MG_ROUND = 2'd3;

   localparam int ROOT_BITS = sem_pkg::CH_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int TRY_BITS  = REM_BITS + 2;
   localparam int STEP_BITS = $clog2(ROOT_BITS);

   logic [1:0]                     state_ff, state_in;
   logic [sem_pkg::SQ_BITS-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [sem_pkg::RAD_BITS-1:0]   rad_ff, rad_in;
   logic                           cap_ff, cap_in;
   logic [REM_BITS-1:0]            rem_ff, rem_in;
   logic [ROOT_BITS-1:0]           root_ff, root_in;
   logic [STEP_BITS-1:0]           step_ff, step_in;
   logic [sem_pkg::CH_BITS-1:0]    mag_ff, mag_in;
   logic                           done_ff, done_in;

   logic [sem_pkg::SUM3_BITS-1:0]  abs_x, abs_y;
   logic [sem_pkg::SQ_BITS:0]      sum_sq;
   logic [TRY_BITS-1:0]            rem_try, trial;

   always_comb begin
      abs_x   = gx[sem_pkg::GRAD_BITS-1] ? sem_pkg::SUM3_BITS'(-gx)
                                         : sem_pkg::SUM3_BITS'(gx);
      abs_y   = gy[sem_pkg::GRAD_BITS-1] ? sem_pkg::SUM3_BITS'(-gy)
                                         : sem_pkg::SUM3_BITS'(gy);
      sum_sq  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      rem_try = {rem_ff, rad_ff[sem_pkg::RAD_BITS-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};

      state_in = state_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      rad_in   = rad_ff;
      cap_in   = cap_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      mag_in   = mag_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         MG_IDLE: begin
            if (start) begin
               sqx_in   = abs_x * abs_x;
               sqy_in   = abs_y * abs_y;
               state_in = MG_SUM;
            end
         end
         MG_SUM: begin
            cap_in   = (sum_sq > (sem_pkg::SQ_BITS+1)'(sem_pkg::MAG_CAP_SUM));
            rad_in   = sum_sq[sem_pkg::RAD_BITS-1:0];
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = MG_ITER;
         end
         MG_ITER: begin
            // one root bit per step, remainder kept for the rounding test
            if (rem_try >= trial) begin
               rem_in  = REM_BITS'(rem_try - trial);
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = REM_BITS'(rem_try);
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            rad_in  = {rad_ff[sem_pkg::RAD_BITS-3:0], 2'b00};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
               state_in = MG_ROUND;
            end
         end
         MG_ROUND: begin
            // round up when the remainder passes the root
            if (cap_ff) begin
               mag_in = sem_pkg::CH_BITS'(sem_pkg::MAG_MAX);
            end else if (rem_ff > REM_BITS'(root_ff)) begin
               mag_in = root_ff + ROOT_BITS'(1);
            end else begin
               mag_in = root_ff;
            end
            done_in  = 1'b1;
            state_in = MG_IDLE;
         end
         default: begin
            state_in = MG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      rad_ff  <= rad_in;
      cap_ff  <= cap_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      mag_ff  <= mag_in;
   end

   assign result.done = done_ff;
   assign result.mag  = mag_ff;

endmodule

[hdl/sobel_edge_magnitude_rgb_unit.sv]
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_unit
// 3x3 sobel edge magnitude on an rgb raster stream, one line store ram
// ---------------------------------------------------------------------------
//
//  channel  | ports                          | direction | beat
//  ---------+--------------------------------+-----------+-------------------------------
//  req      | req_valid / req_stall          | in        | one pixel or one drain beat
//  rsp      | rsp_valid / rsp_stall          | out       | r/g/b magnitude + frame_end
//  csr      | psel penable pwrite paddr ...  | in/out    | line_width at 0, frame_height at 4
//
//  a beat that yields no result takes a line store read, then a write back
//  a beat that yields a result also runs the bit-serial square root, one root bit per step
//  (three lanes side by side) behind the read-modify-write of the line store
//  a drain beat inside the frame is taken and dropped
//  reset is synchronous; the line store ram is not cleared, rows above the
//  frame are masked to black instead
//  a stalled result sits in the output register; the next beat is taken meanwhile
//
module sobel_edge_magnitude_rgb_unit (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sem_pkg::CH_BITS-1:0]        req_red_in,
   input  logic [sem_pkg::CH_BITS-1:0]        req_green_in,
   input  logic [sem_pkg::CH_BITS-1:0]        req_blue_in,
   input  logic                               req_drain,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sem_pkg::CH_BITS-1:0]        rsp_red_out,
   output logic [sem_pkg::CH_BITS-1:0]        rsp_green_out,
   output logic [sem_pkg::CH_BITS-1:0]        rsp_blue_out,
   output logic                               rsp_frame_end,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sem_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [sem_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [sem_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_GO   = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam int CB  = sem_pkg::COL_BITS;
   localparam int WB  = sem_pkg::COL_BITS + 1;
   localparam int IRB = sem_pkg::IROW_BITS;
   localparam int ORB = sem_pkg::OROW_BITS;
   localparam int PB  = sem_pkg::PIX_BITS;
   localparam int NCH = 3;

   // ---------------------------------------------------------------- registers
   logic [2:0]                      state_ff, state_in;
   logic [sem_pkg::LW_BITS-1:0]     line_width_ff, line_width_in;
   logic [sem_pkg::FH_BITS-1:0]     frame_height_ff, frame_height_in;
   logic [CB-1:0]                   icol_ff, icol_in;
   logic [IRB-1:0]                  irow_ff, irow_in;
   logic [CB-1:0]                   ocol_ff, ocol_in;
   logic [ORB-1:0]                  orow_ff, orow_in;
   sem_pkg::pixel_type              win_ff [6];
   sem_pkg::pixel_type              win_in [6];
   sem_pkg::pixel_type              px_ff, px_in;
   logic                            last_ff, last_in;
   sem_pkg::grad_type               gx_ff [NCH];
   sem_pkg::grad_type               gx_in [NCH];
   sem_pkg::grad_type               gy_ff [NCH];
   sem_pkg::grad_type               gy_in [NCH];
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sem_pkg::CH_BITS-1:0]     rsp_mag_ff [NCH];
   logic [sem_pkg::CH_BITS-1:0]     rsp_mag_in [NCH];
   logic                            rsp_end_ff, rsp_end_in;

   // ---------------------------------------------------------------- wires
   logic [WB-1:0]                   eff_w;
   logic [sem_pkg::FH_BITS-1:0]     eff_h;
   logic                            csr_write;
   logic                            accept;
   logic                            in_frame;
   logic                            top_ok, mid_ok;
   logic                            emit, last, keep;
   logic                            out_free;
   logic [WB-1:0]                   icol_next, ocol_next;
   sem_pkg::pixel_type              incoming [3];
   sem_pkg::pixel_type              lcol [3];
   sem_pkg::pixel_type              ccol [3];
   sem_pkg::pixel_type              rcol [3];
   logic                            ram_rd_en, ram_wr_en;
   logic [2*PB-1:0]                 ram_rd_data, ram_wr_data;
   logic                            mag_start;
   sem_pkg::mag_result_type         mag_res [NCH];

   // one channel of a packed pixel, red first
   function automatic logic [sem_pkg::CH_BITS-1:0] chan(
      input sem_pkg::pixel_type px, input int c);
      chan = px[sem_pkg::CH_BITS*(2-c) +: sem_pkg::CH_BITS];
   endfunction

   // weighted 1-2-1 sum of three samples
   function automatic logic [sem_pkg::SUM3_BITS-1:0] sum121(
      input logic [sem_pkg::CH_BITS-1:0] a,
      input logic [sem_pkg::CH_BITS-1:0] b,
      input logic [sem_pkg::CH_BITS-1:0] c);
      sum121 = sem_pkg::SUM3_BITS'(a) + {1'b0, b, 1'b0} + sem_pkg::SUM3_BITS'(c);
   endfunction

   // effective frame size: zero width or height acts as one, width capped at ram depth
   always_comb begin
      if (line_width_ff == '0) begin
         eff_w = WB'(1);
      end else if (int'(line_width_ff) > sem_pkg::MAX_WIDTH) begin
         eff_w = WB'(sem_pkg::MAX_WIDTH);
      end else begin
         eff_w = WB'(line_width_ff);
      end
      eff_h = (frame_height_ff == '0) ? sem_pkg::FH_BITS'(1) : frame_height_ff;
   end

   // ---------------------------------------------------------------- csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (paddr[2])
         sem_pkg::REG_LINE_WIDTH:   prdata = sem_pkg::CSR_DATA_BITS'(line_width_ff);
         sem_pkg::REG_FRAME_HEIGHT: prdata = sem_pkg::CSR_DATA_BITS'(frame_height_ff);
         default:                   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- line store
   // upper and middle rows share one entry: {upper, middle}
   sem_ram #(
      .WIDTH (2 * PB),
      .DEPTH (sem_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (icol_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (icol_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- magnitude lanes
   assign mag_start = (state_ff == ST_GO);

   for (genvar g = 0; g < NCH; g++) begin : g_lane
      sem_magnitude u_mag (
         .clock  (clock),
         .reset  (reset),
         .start  (mag_start),
         .gx     (gx_ff[g]),
         .gy     (gy_ff[g]),
         .result (mag_res[g])
      );
   end

   // ---------------------------------------------------------------- datapath
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign in_frame  = (irow_ff < IRB'(eff_h));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // rows above the frame, or past its end, read as black
   assign top_ok = (irow_ff >= IRB'(2)) && ((irow_ff - IRB'(2)) < IRB'(eff_h));
   assign mid_ok = (irow_ff >= IRB'(1)) && ((irow_ff - IRB'(1)) < IRB'(eff_h));

   assign emit = (irow_ff >= IRB'(2)) || ((irow_ff == IRB'(1)) && (icol_ff != '0));
   assign last = (orow_ff == (eff_h - sem_pkg::FH_BITS'(1)))
              && (WB'(ocol_ff) == (eff_w - WB'(1)));
   // the frame's last result restarts everything and leaves the line store alone
   assign keep = !(emit && last);

   assign icol_next = WB'(icol_ff) + WB'(1);
   assign ocol_next = WB'(ocol_ff) + WB'(1);

   assign ram_rd_en   = accept && !(in_frame && req_drain);
   assign ram_wr_en   = (state_ff == ST_READ) && keep;
   assign ram_wr_data = {ram_rd_data[PB-1:0], px_ff};

   always_comb begin
      incoming[0] = top_ok ? ram_rd_data[2*PB-1:PB] : '0;
      incoming[1] = mid_ok ? ram_rd_data[PB-1:0] : '0;
      incoming[2] = px_ff;

      for (int k = 0; k < 3; k++) begin
         ccol[k] = win_ff[3+k];
         lcol[k] = win_ff[k];
         rcol[k] = incoming[k];
         // frame edges: the column past the right edge and the one wrapped from the row before are black
         if (icol_ff == '0) begin
            rcol[k] = '0;
            if (eff_w < WB'(2)) begin
               lcol[k] = '0;
            end
         end else if (icol_ff == CB'(1)) begin
            lcol[k] = '0;
         end
      end
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in        = state_ff;
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      icol_in         = icol_ff;
      irow_in         = irow_ff;
      ocol_in         = ocol_ff;
      orow_in         = orow_ff;
      win_in          = win_ff;
      px_in           = px_ff;
      last_in         = last_ff;
      gx_in           = gx_ff;
      gy_in           = gy_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_mag_in      = rsp_mag_ff;
      rsp_end_in      = rsp_end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // drain beats inside the frame are dropped here
            if (ram_rd_en) begin
               px_in    = in_frame ? {req_red_in, req_green_in, req_blue_in} : '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            for (int c = 0; c < NCH; c++) begin
               gx_in[c] = $signed({1'b0, sum121(chan(rcol[0], c), chan(rcol[1], c),
                                                chan(rcol[2], c))})
                        - $signed({1'b0, sum121(chan(lcol[0], c), chan(lcol[1], c),
                                                chan(lcol[2], c))});
               gy_in[c] = $signed({1'b0, sum121(chan(lcol[2], c), chan(ccol[2], c),
                                                chan(rcol[2], c))})
                        - $signed({1'b0, sum121(chan(lcol[0], c), chan(ccol[0], c),
                                                chan(rcol[0], c))});
            end
            last_in = last;

            if (keep) begin
               for (int k = 0; k < 3; k++) begin
                  win_in[k]   = win_ff[3+k];
                  win_in[3+k] = incoming[k];
               end
               if (icol_next >= eff_w) begin
                  icol_in = '0;
                  irow_in = irow_ff + IRB'(1);
               end else begin
                  icol_in = CB'(icol_next);
               end
               if (emit) begin
                  if (ocol_next >= eff_w) begin
                     ocol_in = '0;
                     orow_in = orow_ff + ORB'(1);
                  end else begin
                     ocol_in = CB'(ocol_next);
                  end
               end
            end else begin
               // end of frame: back to the first pixel
               for (int k = 0; k < 6; k++) begin
                  win_in[k] = '0;
               end
               icol_in = '0;
               irow_in = '0;
               ocol_in = '0;
               orow_in = '0;
            end

            state_in = emit ? ST_GO : ST_IDLE;
         end
         ST_GO: begin
            state_in = ST_WAIT;
         end
         ST_WAIT, ST_OUT: begin
            if ((state_ff == ST_OUT) || mag_res[0].done) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  for (int c = 0; c < NCH; c++) begin
                     rsp_mag_in[c] = mag_res[c].mag;
                  end
                  rsp_end_in = last_ff;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register write restarts the frame, line store kept
      if (csr_write) begin
         unique case (paddr[2])
            sem_pkg::REG_LINE_WIDTH:   line_width_in   = pwdata[sem_pkg::LW_BITS-1:0];
            sem_pkg::REG_FRAME_HEIGHT: frame_height_in = pwdata[sem_pkg::FH_BITS-1:0];
            default: ;
         endcase
         for (int k = 0; k < 6; k++) begin
            win_in[k] = '0;
         end
         icol_in = '0;
         irow_in = '0;
         ocol_in = '0;
         orow_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         line_width_ff   <= sem_pkg::LW_BITS'(sem_pkg::LW_RESET);
         frame_height_ff <= sem_pkg::FH_BITS'(sem_pkg::FH_RESET);
         icol_ff         <= '0;
         irow_ff         <= '0;
         ocol_ff         <= '0;
         orow_ff         <= '0;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
         icol_ff         <= icol_in;
         irow_ff         <= irow_in;
         ocol_ff         <= ocol_in;
         orow_ff         <= orow_in;
         win_ff          <= win_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      px_ff      <= px_in;
      last_ff    <= last_in;
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      rsp_mag_ff <= rsp_mag_in;
      rsp_end_ff <= rsp_end_in;
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_mag_ff[0];
   assign rsp_green_out = rsp_mag_ff[1];
   assign rsp_blue_out  = rsp_mag_ff[2];
   assign rsp_frame_end = rsp_end_ff;

endmodule

[hdl/sem_checker.sv]
// ---------------------------------------------------------------------------
// sem_checker
// port-level checks of the sobel edge magnitude unit, bound to the top level
// ---------------------------------------------------------------------------
module sem_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [sem_pkg::CH_BITS-1:0]        req_red_in,
   input logic [sem_pkg::CH_BITS-1:0]        req_green_in,
   input logic [sem_pkg::CH_BITS-1:0]        req_blue_in,
   input logic                               req_drain,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [sem_pkg::CH_BITS-1:0]        rsp_red_out,
   input logic [sem_pkg::CH_BITS-1:0]        rsp_green_out,
   input logic [sem_pkg::CH_BITS-1:0]        rsp_blue_out,
   input logic                               rsp_frame_end,
   input logic                               psel,
   input logic                               penable,
   input logic                               pwrite,
   input logic [sem_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input logic [sem_pkg::CSR_DATA_BITS-1:0]  pwdata,
   input logic [sem_pkg::CSR_DATA_BITS-1:0]  prdata,
   input logic                               pready
);

   // a stalled result beat stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_frame_end))
      else $error("stalled result beat changed");

   // a fresh result only appears while the block is busy with a beat
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   // a pixel beat always goes through the line store read
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_drain |=> req_stall)
      else $error("pixel beat did not occupy the line store");

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind sobel_edge_magnitude_rgb_unit sem_checker u_sem_checker (.*);

[tb/tb_sobel_edge_magnitude_rgb_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sobel_edge_magnitude_rgb_unit
// self-checking bench for the 3x3 sobel edge magnitude unit on an rgb stream
// a directed table covers the register extremes, drains inside and after a
// frame and tiny frames with known magnitudes; random frames, mostly of small sizes,
// follow, each beat checked against a behavioral predictor
// ---------------------------------------------------------------------------
module tb_sobel_edge_magnitude_rgb_unit;
   import sem_pkg::*;

   localparam int RANDOM_BEATS  = 650;
   localparam int SETTLE_CYCLES = 32;    // covers the worst beat, with margin
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int DRAIN_LIMIT   = 50000;

   // one result beat as the bench sees it
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } edge_beat_t;

   // three pixels of one column: [0] top, [1] middle, [2] bottom
   typedef logic [2:0][PIX_BITS-1:0] column_t;

   typedef enum logic [1:0] {ROW_BEAT, ROW_SET_WIDTH, ROW_SET_HEIGHT} row_kind_e;

   typedef struct packed {
      row_kind_e  kind;
      logic [15:0] value;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       drain;
      logic       typed;
      edge_beat_t want;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic [CH_BITS-1:0]       req_red_in   = '0;
   logic [CH_BITS-1:0]       req_green_in = '0;
   logic [CH_BITS-1:0]       req_blue_in  = '0;
   logic                     req_drain    = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic [CH_BITS-1:0]       rsp_red_out;
   logic [CH_BITS-1:0]       rsp_green_out;
   logic [CH_BITS-1:0]       rsp_blue_out;
   logic                     rsp_frame_end;

   logic                     psel    = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr   = '0;
   logic [CSR_DATA_BITS-1:0] pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   sobel_edge_magnitude_rgb_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_drain     (req_drain),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor state: its own copy of registers, line stores, window, counters
   // ------------------------------------------------------------------------
   logic [LW_BITS-1:0]  cfg_width  = LW_BITS'(LW_RESET);
   logic [FH_BITS-1:0]  cfg_height = FH_BITS'(FH_RESET);
   logic [PIX_BITS-1:0] upper_store  [MAX_WIDTH];
   logic [PIX_BITS-1:0] middle_store [MAX_WIDTH];
   column_t             win_old = '0;
   column_t             win_new = '0;
   int unsigned         in_col = 0, in_row = 0, out_col = 0, out_row = 0;

   edge_beat_t expected_edges [$];

   // bookkeeping
   int          mismatches    = 0;
   int          beats_sent    = 0;
   int          ignored_drains = 0;
   int          results_seen  = 0;
   int          frames_seen   = 0;
   int          reg_writes    = 0;
   int unsigned send_pct      = 35;
   int unsigned recv_pct      = 68;
   int          hold_requests = 0;

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_store[i]  = '0;
         middle_store[i] = '0;
      end
   end

   // out-of-range widths and heights act as the nearest legal value
   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic int channel_of(logic [PIX_BITS-1:0] px, int sh);
      return int'((px >> sh) & 24'hFF);
   endfunction

   // exact rounded square root of a sum of squares, capped
   function automatic logic [7:0] edge_magnitude(int s);
      if (s > MAG_CAP_SUM) return 8'(MAG_MAX);
      for (int n = 0; n < MAG_MAX; n++) begin
         if (s <= n * n + n) return 8'(n);
      end
      return 8'(MAG_MAX);
   endfunction

   function automatic logic [7:0] sobel_channel(column_t lc, column_t cc, column_t rc, int sh);
      int gx;
      int gy;
      gx = (channel_of(rc[0], sh) + 2 * channel_of(rc[1], sh) + channel_of(rc[2], sh))
         - (channel_of(lc[0], sh) + 2 * channel_of(lc[1], sh) + channel_of(lc[2], sh));
      gy = (channel_of(lc[2], sh) + 2 * channel_of(cc[2], sh) + channel_of(rc[2], sh))
         - (channel_of(lc[0], sh) + 2 * channel_of(cc[0], sh) + channel_of(rc[0], sh));
      return edge_magnitude(gx * gx + gy * gy);
   endfunction

   task automatic restart_frame();
      win_old = '0;
      win_new = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endtask

   // one accepted beat through the predictor; got says whether a result is due
   task automatic predict_edge_beat(input logic [7:0] r, g, b, input logic d,
                                    output logic got, output edge_beat_t res);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      logic [PIX_BITS-1:0] px;
      column_t incoming;
      column_t lc;
      column_t cc;
      column_t rc;
      logic is_last;
      w   = eff_width();
      h   = eff_height();
      got = 1'b0;
      res = '0;
      // drain inside the frame is dropped
      if (in_row < h && d) return;
      col = in_col % MAX_WIDTH;
      // past the last row every beat is a drain, pixel ignored
      px = (in_row < h) ? {r, g, b} : '0;
      // rows above and below the frame read as black
      incoming[0] = (in_row >= 2 && in_row - 2 < h) ? upper_store[col]  : '0;
      incoming[1] = (in_row >= 1 && in_row - 1 < h) ? middle_store[col] : '0;
      incoming[2] = px;
      if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
         lc = win_old;
         cc = win_new;
         rc = incoming;
         // columns left and right of the frame read as black
         if (in_col == 0) begin
            rc = '0;
            if (w < 2) lc = '0;
         end else if (in_col == 1) begin
            lc = '0;
         end
         is_last = (out_row == h - 1) && (out_col == w - 1);
         res.red       = sobel_channel(lc, cc, rc, 16);
         res.green     = sobel_channel(lc, cc, rc, 8);
         res.blue      = sobel_channel(lc, cc, rc, 0);
         res.frame_end = is_last;
         got = 1'b1;
         if (is_last) begin
            restart_frame();
            return;
         end
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row = (out_row + 1) & 32'hFFFF;
         end
      end
      upper_store[col]  = middle_store[col];
      middle_store[col] = px;
      win_old = win_new;
      win_new = incoming;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row = (in_row + 1) & 32'h1FFFF;
      end
   endtask

   // ------------------------------------------------------------------------
   // request side: offer one beat, random gap first, predict on acceptance
   // ------------------------------------------------------------------------
   task automatic offer_beat(input logic [7:0] r, g, b, input logic d,
                             input logic typed, input edge_beat_t want);
      int unsigned gap;
      logic got;
      logic ignored;
      edge_beat_t res;
      gap = ($urandom_range(0, 99) < send_pct) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      req_drain    <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge
      ignored = d && (in_row < eff_height());
      predict_edge_beat(r, g, b, d, got, res);
      if (typed) expected_edges.push_back(want);
      else if (got) expected_edges.push_back(res);
      if (ignored) ignored_drains++;
      else beats_sent++;
   endtask

   // registers change only with the pipe empty
   task automatic write_register(input logic idx, input logic [15:0] value);
      req_valid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      // setup then access
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      // written at this edge: predictor follows and restarts the frame
      if (idx == REG_LINE_WIDTH) cfg_width = value[LW_BITS-1:0];
      else cfg_height = value;
      restart_frame();
      reg_writes++;
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == REG_LINE_WIDTH && prdata[LW_BITS-1:0] != value[LW_BITS-1:0]) begin
         $display("%0t ns: line_width readback mismatch, expected %0d, got %0d",
                  $time, value[LW_BITS-1:0], prdata[LW_BITS-1:0]);
         mismatches++;
      end
      if (idx == REG_FRAME_HEIGHT && prdata[FH_BITS-1:0] != value) begin
         $display("%0t ns: frame_height readback mismatch, expected %0d, got %0d",
                  $time, value, prdata[FH_BITS-1:0]);
         mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // mostly random, with black and full-scale values for hard edges
   function automatic logic [7:0] channel_value();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) return 8'h00;
      if (sel < 4) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic stim_row_t beat_row(logic [7:0] r, g, b, logic d);
      stim_row_t row;
      row       = '0;
      row.kind  = ROW_BEAT;
      row.red   = r;
      row.green = g;
      row.blue  = b;
      row.drain = d;
      return row;
   endfunction

   function automatic stim_row_t typed_row(logic [7:0] r, g, b, logic d, edge_beat_t want);
      stim_row_t row;
      row       = beat_row(r, g, b, d);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic stim_row_t reg_row(row_kind_e kind, logic [15:0] value);
      stim_row_t row;
      row       = '0;
      row.kind  = kind;
      row.value = value;
      return row;
   endfunction

   // ------------------------------------------------------------------------
   // result side: random stall, plus one long hold-off on request
   // ------------------------------------------------------------------------
   int hold_left    = 0;
   int holds_served = 0;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_pct);
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // scoreboard: every accepted result against the oldest expectation
   always @(posedge clock) begin
      edge_beat_t exp_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_frame_end) frames_seen++;
         if (expected_edges.size() == 0) begin
            $display("%0t ns: result with nothing expected, got r %0d g %0d b %0d end %0d",
                     $time, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end);
            mismatches++;
         end else begin
            exp_beat = expected_edges.pop_front();
            check_field("red_out",   exp_beat.red,       rsp_red_out);
            check_field("green_out", exp_beat.green,     rsp_green_out);
            check_field("blue_out",  exp_beat.blue,      rsp_blue_out);
            check_field("frame_end", exp_beat.frame_end, rsp_frame_end);
         end
      end
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_edges.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      stim_row_t   directed [$];
      stim_row_t   row;
      edge_beat_t  none;
      int unsigned w_set, h_set, w_eff, h_eff, frames, pixels, random_start, progress;
      int unsigned drain_wait;
      logic        broken;
      logic        pressure_done;

      none = '0;
      pressure_done = 1'b0;

      // ---- directed table ----
      // reset config 640x480: drain inside the frame is dropped
      directed.push_back(beat_row(8'h00, 8'h00, 8'h00, 1'b1));
      directed.push_back(beat_row(8'hA5, 8'h5A, 8'hFF, 1'b0));
      // 2x1 full-scale frame with a stray drain: both outputs saturate
      directed.push_back(reg_row(ROW_SET_WIDTH, 16'd2));
      directed.push_back(reg_row(ROW_SET_HEIGHT, 16'd1));
      directed.push_back(beat_row(8'hFF, 8'hFF, 8'hFF, 1'b0));
      directed.push_back(beat_row(8'h00, 8'h00, 8'h00, 1'b1));
      directed.push_back(beat_row(8'hFF, 8'hFF, 8'hFF, 1'b0));
      directed.push_back(beat_row(8'h00, 8'h00, 8'h00, 1'b1));
      directed.push_back(typed_row(8'h00, 8'h00, 8'h00, 1'b1, {8'd255, 8'd255, 8'd255, 1'b0}));
      directed.push_back(typed_row(8'h00, 8'h00, 8'h00, 1'b1, {8'd255, 8'd255, 8'd255, 1'b1}));
      // single-pixel frame: no neighbors, magnitude zero
      directed.push_back(reg_row(ROW_SET_WIDTH, 16'd1));
      directed.push_back(reg_row(ROW_SET_HEIGHT, 16'd1));
      directed.push_back(beat_row(8'hFF, 8'hFF, 8'hFF, 1'b0));
      directed.push_back(beat_row(8'h00, 8'h00, 8'h00, 1'b1));
      directed.push_back(typed_row(8'h00, 8'h00, 8'h00, 1'b1, {24'd0, 1'b1}));
      // next frame starts right away; pixels past the frame flush like drains
      directed.push_back(beat_row(8'd12, 8'd34, 8'd56, 1'b0));
      directed.push_back(beat_row(8'd200, 8'd100, 8'd50, 1'b0));
      directed.push_back(typed_row(8'hFF, 8'h00, 8'hFF, 1'b0, {24'd0, 1'b1}));
      // zero width and height act as one
      directed.push_back(reg_row(ROW_SET_WIDTH, 16'd0));
      directed.push_back(reg_row(ROW_SET_HEIGHT, 16'd0));
      directed.push_back(beat_row(8'd1, 8'd2, 8'd3, 1'b0));
      directed.push_back(beat_row(8'h00, 8'h00, 8'h00, 1'b1));
      directed.push_back(typed_row(8'h00, 8'h00, 8'h00, 1'b1, {24'd0, 1'b1}));
      // 2x2 mixed colors, predicted
      directed.push_back(reg_row(ROW_SET_WIDTH, 16'd2));
      directed.push_back(reg_row(ROW_SET_HEIGHT, 16'd2));
      directed.push_back(beat_row(8'd10, 8'd200, 8'd0, 1'b0));
      directed.push_back(beat_row(8'd255, 8'd0, 8'd128, 1'b0));
      directed.push_back(beat_row(8'd0, 8'd255, 8'd64, 1'b0));
      directed.push_back(beat_row(8'd128, 8'd128, 8'd255, 1'b0));
      directed.push_back(beat_row(8'h00, 8'h00, 8'h00, 1'b1));
      directed.push_back(beat_row(8'h00, 8'h00, 8'h00, 1'b1));
      directed.push_back(beat_row(8'h00, 8'h00, 8'h00, 1'b1));
      // widest-than-legal width and tallest frame, a couple of pixels
      directed.push_back(reg_row(ROW_SET_WIDTH, 16'd2047));
      directed.push_back(reg_row(ROW_SET_HEIGHT, 16'd65535));
      directed.push_back(beat_row(8'h3C, 8'hC3, 8'h81, 1'b0));
      directed.push_back(beat_row(8'h7E, 8'h18, 8'hE7, 1'b0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         case (row.kind)
            ROW_SET_WIDTH: begin
               write_register(REG_LINE_WIDTH, row.value);
            end
            ROW_SET_HEIGHT: begin
               write_register(REG_FRAME_HEIGHT, row.value);
            end
            default: begin
               offer_beat(row.red, row.green, row.blue, row.drain, row.typed, row.want);
            end
         endcase
      end

      // ---- random frames ----
      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         progress = beats_sent - random_start;
         // receiver-heavy idling, then sender-heavy, then none
         if (progress < RANDOM_BEATS / 3) begin
            send_pct = 35;
            recv_pct = 68;
         end else if (progress < 2 * RANDOM_BEATS / 3) begin
            send_pct = 68;
            recv_pct = 35;
         end else begin
            send_pct = 0;
            recv_pct = 0;
         end

         broken = 1'b0;
         frames = 1;
         if (send_pct == 0 && !pressure_done) begin
            // long hold-off on the result side while a dense frame streams in
            w_set = $urandom_range(3, 6);
            h_set = 4;
         end else begin
            case ($urandom_range(0, 19))
               0: begin
                  // huge sizes: a partial frame only
                  case ($urandom_range(0, 3))
                     0: w_set = 1024;
                     1: w_set = 2047;
                     2: w_set = 1025;
                     default: w_set = $urandom_range(600, 1023);
                  endcase
                  case ($urandom_range(0, 2))
                     0: h_set = 65535;
                     1: h_set = 0;
                     default: h_set = $urandom_range(1, 65535);
                  endcase
                  broken = 1'b1;
               end
               1, 2: begin
                  w_set = $urandom_range(7, 20);
                  h_set = $urandom_range(1, 3);
               end
               default: begin
                  w_set = $urandom_range(0, 6);
                  h_set = $urandom_range(0, 5);
                  frames = $urandom_range(1, 3);
               end
            endcase
         end

         write_register(REG_LINE_WIDTH, 16'(w_set));
         write_register(REG_FRAME_HEIGHT, 16'(h_set));
         w_eff = eff_width();
         h_eff = eff_height();

         if (send_pct == 0 && !pressure_done) begin
            pressure_done = 1'b1;
            hold_requests++;
         end

         for (int f = 0; f < frames; f++) begin
            if (broken) pixels = $urandom_range(20, 60);
            else if ($urandom_range(0, 99) < 8) begin
               // cut the frame short; the next register write restarts it
               broken = 1'b1;
               pixels = $urandom_range(1, w_eff * h_eff);
            end else pixels = w_eff * h_eff;

            for (int p = 0; p < pixels; p++) begin
               if ($urandom_range(0, 99) < 6)
                  offer_beat(channel_value(), channel_value(), channel_value(), 1'b1, 1'b0, none);
               offer_beat(channel_value(), channel_value(), channel_value(), 1'b0, 1'b0, none);
            end
            if (broken) break;

            // flush: drains, some of them pixels that land past the frame
            for (int k = 0; k <= w_eff; k++) begin
               if ($urandom_range(0, 3) == 0)
                  offer_beat(channel_value(), channel_value(), channel_value(), 1'b0, 1'b0, none);
               else
                  offer_beat(channel_value(), channel_value(), channel_value(), 1'b1, 1'b0, none);
            end
         end
      end

      // ---- wind down ----
      req_valid <= 1'b0;
      drain_wait = 0;
      while (expected_edges.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_edges.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time, expected_edges.size());
         mismatches += expected_edges.size();
      end

      $display("run covered %0d pixel/drain beats plus %0d dropped drains, %0d register writes",
               beats_sent, ignored_drains, reg_writes);
      $display("%0d edge results compared over %0d completed frames, %0d mismatches",
               results_seen, frames_seen, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/sem_pkg.sv
hdl/sem_ram.sv
hdl/sem_magnitude.sv
hdl/sobel_edge_magnitude_rgb_unit.sv
hdl/sem_checker.sv
tb/tb_sobel_edge_magnitude_rgb_unit.sv
